// ----- hdl/mmt_pkg.sv -----
package mmt_pkg;

    localparam int VAL_W = 32;
    localparam int ACC_W = 52;
    localparam int PROD_W = 2 * VAL_W;
    localparam int Q_SHIFT = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [2:0] KIND_LOAD_A = 3'd0;
    localparam logic [2:0] KIND_LOAD_B = 3'd1;
    localparam logic [2:0] KIND_LOAD_G = 3'd2;
    localparam logic [2:0] KIND_LOAD_P = 3'd3;
    localparam logic [2:0] KIND_START  = 3'd4;

    localparam logic [1:0] MODE_FWD    = 2'd0;
    localparam logic [1:0] MODE_GRAD_A = 2'd1;
    localparam logic [1:0] MODE_GRAD_B = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_M  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_K = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_N  = 2'd3;

    typedef struct packed {
        logic [2:0]              kind;
        logic [2:0]              row;
        logic [2:0]              col;
        logic signed [VAL_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic [2:0]              out_row;
        logic [2:0]              out_col;
        logic signed [VAL_W-1:0] result;
        logic                    saturated;
        logic                    last;
    } out_word_t;

    typedef struct packed {
        logic en;
        logic load;
    } cell_ctrl_t;

endpackage

// ----- hdl/matrix_multiply_tile_with_gradients.sv -----
// Tile matrix engine, Q16.16. Load words (kinds 0..3) write one element of A, B, the output
// gradient G or the prior P. A start word computes the result of the
// current mode (A*B, P + G*B^T or P + A^T*G) and emits it row-major, last on the final element.
// Per result row, a ring of MAX_DIM accumulator cells rotates once per pass: one pass loads the
// prior (zero in forward mode), then one pass per inner step adds a product, one multiply per
// cycle unless issue waits at a row start for the output queue to empty. The multiplier is the
// one shared unit; the input is stalled until the run has drained into the output queue.
module matrix_multiply_tile_with_gradients
    import mmt_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  in_word_t              item,
    output logic                  res_valid,
    input  logic                  res_stall,
    output out_word_t             res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW = $clog2(MAX_DIM + 1);
    localparam int IW = $clog2(MAX_DIM);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW = $clog2(DEPTH);
    localparam logic [VAL_W-1:0] ONE_Q = VAL_W'(1 << Q_SHIFT);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] a, input logic [IW-1:0] b);
        addr_of = AW'(int'(a) * MAX_DIM + int'(b));
    endfunction

    function automatic logic [CW-1:0] eff_dim(input logic [CFG_DATA_W-1:0] d);
        if (d == '0)
            eff_dim = CW'(1);
        else if (int'(d) > MAX_DIM)
            eff_dim = CW'(MAX_DIM);
        else
            eff_dim = CW'(d);
    endfunction

    // configuration
    logic [1:0]            mode_reg;
    logic [CFG_DATA_W-1:0] rows_m_reg, inner_k_reg, cols_n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_FWD;
            rows_m_reg  <= CFG_DATA_W'(8);
            inner_k_reg <= CFG_DATA_W'(8);
            cols_n_reg  <= CFG_DATA_W'(8);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:    mode_reg    <= cfg_data[1:0];
                REG_ROWS_M:  rows_m_reg  <= cfg_data;
                REG_INNER_K: inner_k_reg <= cfg_data;
                REG_COLS_N:  cols_n_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [CW-1:0] m_eff, k_eff, n_eff, rows_eff, cols_eff, steps_eff;
    logic          is_ga, is_gb;

    always_comb
    begin
        m_eff = eff_dim(rows_m_reg);
        k_eff = eff_dim(inner_k_reg);
        n_eff = eff_dim(cols_n_reg);
        is_ga = (mode_reg == MODE_GRAD_A);
        is_gb = (mode_reg == MODE_GRAD_B);
        if (is_ga)
        begin
            rows_eff = m_eff; cols_eff = k_eff; steps_eff = n_eff;
        end
        else if (is_gb)
        begin
            rows_eff = k_eff; cols_eff = n_eff; steps_eff = m_eff;
        end
        else
        begin
            rows_eff = m_eff; cols_eff = n_eff; steps_eff = k_eff;
        end
    end

    // sequencer
    logic          state_reg, state_next;
    logic [CW-1:0] r_reg, r_next, t_reg, t_next;
    logic [IW-1:0] c_reg, c_next;
    logic [CW-1:0] fifo_cnt_reg;
    logic          s1_vld_reg, s2_vld_reg;
    logic          issue, accept, is_load, in_range;

    assign item_stall = (state_reg != ST_IDLE) || s1_vld_reg || s2_vld_reg;
    assign accept     = item_valid && !item_stall;
    assign in_range   = (int'(item.row) < MAX_DIM) && (int'(item.col) < MAX_DIM);
    assign is_load    = accept && (item.kind <= KIND_LOAD_P) && in_range;

    assign issue = (state_reg == ST_RUN)
                && !(c_reg == '0 && t_reg == '0 && r_reg != '0 && fifo_cnt_reg != '0);

    always_comb
    begin
        state_next = state_reg;
        r_next = r_reg;
        t_next = t_reg;
        c_next = c_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && item.kind == KIND_START)
                begin
                    state_next = ST_RUN;
                    r_next = '0;
                    t_next = '0;
                    c_next = '0;
                end
            end
            ST_RUN:
            begin
                if (issue)
                begin
                    if (c_reg == IW'(MAX_DIM - 1))
                    begin
                        c_next = '0;
                        if (r_reg == rows_eff)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (t_reg == steps_eff)
                        begin
                            t_next = '0;
                            r_next = r_reg + CW'(1);
                        end
                        else
                        begin
                            t_next = t_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        c_next = c_reg + IW'(1);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            r_reg <= '0;
            t_reg <= '0;
            c_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            r_reg <= r_next;
            t_reg <= t_next;
            c_reg <= c_next;
        end
    end

    // store addressing
    logic [IW-1:0] ri, ci, ti;
    logic [AW-1:0] a_raddr, b_raddr, g_raddr, p_raddr, waddr;

    assign ri = r_reg[IW-1:0];
    assign ci = c_reg;
    assign ti = IW'(t_reg - CW'(1));
    assign waddr = AW'(int'(item.row) * MAX_DIM + int'(item.col));

    always_comb
    begin
        a_raddr = is_gb ? addr_of(ti, ri) : addr_of(ri, ti);
        b_raddr = is_ga ? addr_of(ci, ti) : addr_of(ti, ci);
        g_raddr = is_gb ? addr_of(ti, ci) : addr_of(ri, ti);
        p_raddr = addr_of(ri, ci);
    end

    logic [VAL_W-1:0] a_rd, b_rd, g_rd, p_rd;

    mmt_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram_a (
        .clk(clk), .we(is_load && item.kind == KIND_LOAD_A), .waddr(waddr),
        .wdata(item.value), .raddr(a_raddr), .rdata(a_rd));
    mmt_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram_b (
        .clk(clk), .we(is_load && item.kind == KIND_LOAD_B), .waddr(waddr),
        .wdata(item.value), .raddr(b_raddr), .rdata(b_rd));
    mmt_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram_g (
        .clk(clk), .we(is_load && item.kind == KIND_LOAD_G), .waddr(waddr),
        .wdata(item.value), .raddr(g_raddr), .rdata(g_rd));
    mmt_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram_p (
        .clk(clk), .we(is_load && item.kind == KIND_LOAD_P), .waddr(waddr),
        .wdata(item.value), .raddr(p_raddr), .rdata(p_rd));

    // stage 1: store data, stage 2: product
    logic          s1_init_reg, s1_zero_reg, s1_emit_reg, s1_lastr_reg;
    logic [IW-1:0] s1_c_reg, s1_erow_reg;
    logic          s2_init_reg, s2_emit_reg, s2_lastr_reg;
    logic [IW-1:0] s2_c_reg, s2_erow_reg;
    logic signed [PROD_W-1:0] s2_prod_reg;
    logic signed [VAL_W-1:0]  x_op, y_op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= issue;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_init_reg  <= (t_reg == '0);
        s1_zero_reg  <= (t_reg == '0) && (!(is_ga || is_gb) || r_reg == rows_eff);
        s1_emit_reg  <= (t_reg == '0) && (r_reg != '0);
        s1_lastr_reg <= (r_reg == rows_eff);
        s1_erow_reg  <= IW'(r_reg - CW'(1));
        s1_c_reg     <= c_reg;
        s2_init_reg  <= s1_init_reg;
        s2_emit_reg  <= s1_emit_reg;
        s2_lastr_reg <= s1_lastr_reg;
        s2_erow_reg  <= s1_erow_reg;
        s2_c_reg     <= s1_c_reg;
        s2_prod_reg  <= PROD_W'(x_op) * PROD_W'(y_op);
    end

    always_comb
    begin
        if (s1_init_reg)
        begin
            x_op = s1_zero_reg ? '0 : $signed(p_rd);
            y_op = $signed(ONE_Q);
        end
        else if (is_ga)
        begin
            x_op = $signed(g_rd);
            y_op = $signed(b_rd);
        end
        else if (is_gb)
        begin
            x_op = $signed(a_rd);
            y_op = $signed(g_rd);
        end
        else
        begin
            x_op = $signed(a_rd);
            y_op = $signed(b_rd);
        end
    end

    // accumulator ring
    logic signed [ACC_W-1:0] ring_q [MAX_DIM];
    logic signed [ACC_W-1:0] head_add;
    cell_ctrl_t              head_ctrl, body_ctrl;

    assign head_add = ACC_W'(s2_prod_reg >>> Q_SHIFT);
    assign head_ctrl = '{en: s2_vld_reg, load: s2_init_reg};
    assign body_ctrl = '{en: s2_vld_reg, load: 1'b0};

    for (genvar i = 0; i < MAX_DIM; i++)
    begin : g_ring
        if (i == 0)
        begin : g_head
            mmt_cell u_cell (
                .clk(clk), .ctrl(head_ctrl), .d(ring_q[MAX_DIM-1]),
                .add(head_add), .q(ring_q[0]));
        end
        else
        begin : g_body
            mmt_cell u_cell (
                .clk(clk), .ctrl(body_ctrl), .d(ring_q[i-1]),
                .add('0), .q(ring_q[i]));
        end
    end

    // saturate and queue
    logic signed [ACC_W-1:0] tail;
    logic                    sat, push, pop;
    out_word_t               push_word;

    assign tail = ring_q[MAX_DIM-1];
    assign sat  = !((&tail[ACC_W-1:VAL_W-1]) || !(|tail[ACC_W-1:VAL_W-1]));
    assign push = s2_vld_reg && s2_emit_reg && (CW'(s2_c_reg) < cols_eff);

    always_comb
    begin
        push_word.out_row   = 3'(s2_erow_reg);
        push_word.out_col   = 3'(s2_c_reg);
        push_word.saturated = sat;
        push_word.last      = s2_lastr_reg && (CW'(s2_c_reg) == cols_eff - CW'(1));
        if (sat)
            push_word.result = tail[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
                                             : {1'b0, {(VAL_W-1){1'b1}}};
        else
            push_word.result = tail[VAL_W-1:0];
    end

    out_word_t     fifo_mem [MAX_DIM];
    logic [IW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic          res_valid_reg;
    out_word_t     res_reg;

    assign pop = (fifo_cnt_reg != '0) && (!res_valid_reg || !res_stall);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= push_word;
        end
        if (pop)
        begin
            res_reg <= fifo_mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fifo_cnt_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == IW'(MAX_DIM - 1)) ? '0 : wr_ptr_reg + IW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == IW'(MAX_DIM - 1)) ? '0 : rd_ptr_reg + IW'(1);
            fifo_cnt_reg <= fifo_cnt_reg + CW'(push) - CW'(pop);
            if (pop)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    assign res_valid = res_valid_reg;
    assign res = res_reg;

    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(fifo_cnt_reg) <= MAX_DIM)
        else $error("output queue over capacity");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (int'(fifo_cnt_reg) < MAX_DIM) || pop)
        else $error("push into full output queue");

    a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
        s2_vld_reg |-> $past(s1_vld_reg))
        else $error("product stage without data stage");

    a_idle_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !s1_vld_reg && !s2_vld_reg) |=> !s2_vld_reg)
        else $error("ring update while idle");

endmodule

// ----- hdl/mmt_ram.sv -----
module mmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/mmt_cell.sv -----
module mmt_cell
    import mmt_pkg::*;
(
    input  logic                    clk,
    input  cell_ctrl_t              ctrl,
    input  logic signed [ACC_W-1:0] d,
    input  logic signed [ACC_W-1:0] add,
    output logic signed [ACC_W-1:0] q
);

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.en)
        begin
            acc_next = ctrl.load ? add : d + add;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign q = acc_reg;

endmodule

// ----- test/tb_matrix_multiply_tile_with_gradients.sv -----
module tb_matrix_multiply_tile_with_gradients;
    import mmt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIM = 8;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int SETTLE_CYCLES = 24;
    localparam int RAND_PER_PHASE = 8;
    localparam logic [2:0] KIND_UNUSED_LO  = 3'd5;
    localparam logic [2:0] KIND_UNUSED_MID = 3'd6;
    localparam logic [2:0] KIND_UNUSED_HI  = 3'd7;
    localparam logic [1:0] MODE_SPARE      = 2'd3;

    typedef struct {
        logic [2:0]  kind;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
        bit          typed;
        logic [31:0] res;
        bit          sat;
    } dir_row_t;

    typedef struct {
        logic [1:0] mode;
        logic [3:0] m;
        logic [3:0] k;
        logic [3:0] n;
    } tile_cfg_t;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    in_word_t  item;
    logic      res_valid;
    logic      res_stall;
    out_word_t res;
    logic      cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic signed [31:0] tile_mem [4][DIM*DIM];
    bit                 tile_written [4][DIM*DIM];
    logic [3:0]         shadow_cfg [4];
    out_word_t          pending_results [$];

    int tx_idle_pct;
    int rx_idle_pct;
    int words_sent;
    int results_seen;
    int starts_sent;
    int fails;
    int quiet_cycles;

    dir_row_t dir_tab [20] = '{
        '{KIND_LOAD_A, 3'd0, 3'd0, 32'h0001_0000, 1'b0, 32'h0, 1'b0},
        '{KIND_LOAD_B, 3'd0, 3'd0, 32'h0002_0000, 1'b0, 32'h0, 1'b0},
        '{KIND_START,  3'd0, 3'd0, 32'h0,         1'b1, 32'h0002_0000, 1'b0},
        '{KIND_LOAD_A, 3'd0, 3'd0, 32'h7fff_ffff, 1'b0, 32'h0, 1'b0},
        '{KIND_LOAD_B, 3'd0, 3'd0, 32'h7fff_ffff, 1'b0, 32'h0, 1'b0},
        '{KIND_START,  3'd7, 3'd7, 32'hffff_ffff, 1'b1, 32'h7fff_ffff, 1'b1},
        '{KIND_LOAD_A, 3'd0, 3'd0, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
        '{KIND_START,  3'd0, 3'd0, 32'h0,         1'b1, 32'h8000_0000, 1'b1},
        '{KIND_LOAD_B, 3'd0, 3'd0, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
        '{KIND_START,  3'd0, 3'd0, 32'h0,         1'b1, 32'h7fff_ffff, 1'b1},
        '{KIND_LOAD_A, 3'd0, 3'd0, 32'hffff_ffff, 1'b0, 32'h0, 1'b0},
        '{KIND_LOAD_B, 3'd0, 3'd0, 32'h0000_0001, 1'b0, 32'h0, 1'b0},
        '{KIND_START,  3'd0, 3'd0, 32'h0,         1'b1, 32'hffff_ffff, 1'b0},
        '{KIND_LOAD_G, 3'd7, 3'd7, 32'hffff_ffff, 1'b0, 32'h0, 1'b0},
        '{KIND_LOAD_P, 3'd7, 3'd7, 32'h0,         1'b0, 32'h0, 1'b0},
        '{KIND_UNUSED_LO,  3'd7, 3'd7, 32'h7fff_ffff, 1'b0, 32'h0, 1'b0},
        '{KIND_UNUSED_MID, 3'd0, 3'd7, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
        '{KIND_UNUSED_HI,  3'd7, 3'd0, 32'h5555_aaaa, 1'b0, 32'h0, 1'b0},
        '{KIND_LOAD_A, 3'd7, 3'd7, 32'h1234_5678, 1'b0, 32'h0, 1'b0},
        '{KIND_START,  3'd0, 3'd0, 32'h0,         1'b0, 32'h0, 1'b0}
    };

    tile_cfg_t phase_tab [7] = '{
        '{MODE_FWD,    4'd3,  4'd2,  4'd4},
        '{MODE_GRAD_A, 4'd2,  4'd3,  4'd2},
        '{MODE_GRAD_B, 4'd4,  4'd2,  4'd3},
        '{MODE_SPARE,  4'd0,  4'd15, 4'd1},
        '{MODE_GRAD_A, 4'd15, 4'd1,  4'd0},
        '{MODE_GRAD_B, 4'd1,  4'd0,  4'd15},
        '{MODE_FWD,    4'd8,  4'd8,  4'd8}
    };

    matrix_multiply_tile_with_gradients u_top (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res(res),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int eff_dim(logic [3:0] d);
        if (d == 4'd0)
            return 1;
        if (d > DIM)
            return DIM;
        return int'(d);
    endfunction

    // which store entries the current shape reads
    function automatic bit tile_needs(int store, int r, int c);
        int m;
        int k;
        int n;
        logic [1:0] md;
        m = eff_dim(shadow_cfg[REG_ROWS_M]);
        k = eff_dim(shadow_cfg[REG_INNER_K]);
        n = eff_dim(shadow_cfg[REG_COLS_N]);
        md = shadow_cfg[REG_MODE][1:0];
        case (store)
            KIND_LOAD_A: return md != MODE_GRAD_A && r < m && c < k;
            KIND_LOAD_B: return md != MODE_GRAD_B && r < k && c < n;
            KIND_LOAD_G: return (md == MODE_GRAD_A || md == MODE_GRAD_B) && r < m && c < n;
            default:
            begin
                if (md == MODE_GRAD_A)
                    return r < m && c < k;
                if (md == MODE_GRAD_B)
                    return r < k && c < n;
                return 0;
            end
        endcase
    endfunction

    function automatic longint q16_mul(logic signed [31:0] a, logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return p >>> 16;
    endfunction

    function automatic void predict_tile();
        int m;
        int k;
        int n;
        int rows;
        int cols;
        logic [1:0] md;
        longint acc;
        out_word_t w;
        m = eff_dim(shadow_cfg[REG_ROWS_M]);
        k = eff_dim(shadow_cfg[REG_INNER_K]);
        n = eff_dim(shadow_cfg[REG_COLS_N]);
        md = shadow_cfg[REG_MODE][1:0];
        rows = (md == MODE_GRAD_B) ? k : m;
        cols = (md == MODE_GRAD_A) ? k : n;
        for (int r = 0; r < rows; r++)
        begin
            for (int c = 0; c < cols; c++)
            begin
                if (md == MODE_GRAD_A)
                begin
                    acc = longint'(tile_mem[KIND_LOAD_P][r*DIM+c]);
                    for (int t = 0; t < n; t++)
                        acc += q16_mul(tile_mem[KIND_LOAD_G][r*DIM+t],
                                       tile_mem[KIND_LOAD_B][c*DIM+t]);
                end
                else if (md == MODE_GRAD_B)
                begin
                    acc = longint'(tile_mem[KIND_LOAD_P][r*DIM+c]);
                    for (int t = 0; t < m; t++)
                        acc += q16_mul(tile_mem[KIND_LOAD_A][t*DIM+r],
                                       tile_mem[KIND_LOAD_G][t*DIM+c]);
                end
                else
                begin
                    acc = 0;
                    for (int t = 0; t < k; t++)
                        acc += q16_mul(tile_mem[KIND_LOAD_A][r*DIM+t],
                                       tile_mem[KIND_LOAD_B][t*DIM+c]);
                end
                w.out_row = r[2:0];
                w.out_col = c[2:0];
                w.saturated = 1'b0;
                if (acc > 64'sd2147483647)
                begin
                    acc = 64'sd2147483647;
                    w.saturated = 1'b1;
                end
                else if (acc < -64'sd2147483648)
                begin
                    acc = -64'sd2147483648;
                    w.saturated = 1'b1;
                end
                w.result = acc[31:0];
                w.last = (r == rows - 1) && (c == cols - 1);
                pending_results = {pending_results, w};
            end
        end
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(9))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $urandom_range(32'h8_0000) - 32'h4_0000;
        endcase
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_word(in_word_t w, bit typed, logic [31:0] t_res, bit t_sat);
        out_word_t e;
        if ($urandom_range(99) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < tx_idle_pct)
                @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= w;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        words_sent++;
        if (w.kind <= KIND_LOAD_P)
        begin
            tile_mem[w.kind][w.row*DIM+w.col] = w.value;
            tile_written[w.kind][w.row*DIM+w.col] = 1'b1;
        end
        else if (w.kind == KIND_START)
        begin
            starts_sent++;
            if (typed)
            begin
                e.out_row = 3'd0;
                e.out_col = 3'd0;
                e.result = t_res;
                e.saturated = t_sat;
                e.last = 1'b1;
                pending_results = {pending_results, e};
            end
            else
                predict_tile();
        end
        @(negedge clk);
    endtask

    task automatic send_plain(logic [2:0] kind, int r, int c, logic [31:0] v);
        in_word_t w;
        w.kind = kind;
        w.row = r[2:0];
        w.col = c[2:0];
        w.value = v;
        send_word(w, 1'b0, 32'h0, 1'b0);
    endtask

    // all store entries read by a start must have been loaded
    task automatic fill_then_start();
        for (int s = KIND_LOAD_A; s <= KIND_LOAD_P; s++)
            for (int i = 0; i < DIM * DIM; i++)
                if (tile_needs(s, i / DIM, i % DIM) && !tile_written[s][i])
                    send_plain(s[2:0], i / DIM, i % DIM, rand_value());
        send_plain(KIND_START, $urandom_range(7), $urandom_range(7), $urandom);
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_shape(tile_cfg_t t);
        logic [3:0] vals [4];
        vals[REG_MODE] = {2'b00, t.mode};
        vals[REG_ROWS_M] = t.m;
        vals[REG_INNER_K] = t.k;
        vals[REG_COLS_N] = t.n;
        for (int i = 0; i < 4; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= i[CFG_IDX_W-1:0];
            cfg_data <= vals[i];
            shadow_cfg[i] = vals[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    always @(negedge clk)
        res_stall <= ($urandom_range(99) < rx_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result word row %0d col %0d", res.out_row, res.out_col);
                fails++;
            end
            else
            begin
                out_word_t e;
                e = pending_results.pop_front();
                if (res.out_row !== e.out_row)
                begin
                    $error("out_row expected %0d got %0d", e.out_row, res.out_row);
                    fails++;
                end
                if (res.out_col !== e.out_col)
                begin
                    $error("out_col expected %0d got %0d", e.out_col, res.out_col);
                    fails++;
                end
                if (res.result !== e.result)
                begin
                    $error("result expected %h got %h", e.result, res.result);
                    fails++;
                end
                if (res.saturated !== e.saturated)
                begin
                    $error("saturated expected %b got %b", e.saturated, res.saturated);
                    fails++;
                end
                if (res.last !== e.last)
                begin
                    $error("last expected %b got %b", e.last, res.last);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (res_valid && !res_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no progress, %0d results outstanding",
                     pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        tile_cfg_t one;
        int r;
        int roll;
        in_word_t w;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        res_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        tx_idle_pct = 23;
        rx_idle_pct = 47;
        words_sent = 0;
        results_seen = 0;
        starts_sent = 0;
        fails = 0;
        quiet_cycles = 0;
        shadow_cfg[REG_MODE] = {2'b00, MODE_FWD};
        shadow_cfg[REG_ROWS_M] = 4'd8;
        shadow_cfg[REG_INNER_K] = 4'd8;
        shadow_cfg[REG_COLS_N] = 4'd8;
        for (int s = 0; s < 4; s++)
            for (int i = 0; i < DIM * DIM; i++)
            begin
                tile_mem[s][i] = '0;
                tile_written[s][i] = 1'b0;
            end
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        one = '{MODE_FWD, 4'd1, 4'd1, 4'd1};
        write_shape(one);
        foreach (dir_tab[i])
        begin
            w.kind = dir_tab[i].kind;
            w.row = dir_tab[i].row;
            w.col = dir_tab[i].col;
            w.value = dir_tab[i].value;
            send_word(w, dir_tab[i].typed, dir_tab[i].res, dir_tab[i].sat);
        end
        wait_drained();

        foreach (phase_tab[p])
        begin
            if (p == 3)
            begin
                tx_idle_pct = 47;
                rx_idle_pct = 23;
            end
            else if (p == 5)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_shape(phase_tab[p]);
            for (int i = 0; i < RAND_PER_PHASE; i++)
            begin
                roll = $urandom_range(99);
                if (roll < 60)
                begin
                    r = $urandom_range(3);
                    send_plain(r[2:0], $urandom_range(eff_dim(phase_tab[p].m) - 1),
                               $urandom_range(eff_dim(phase_tab[p].k) - 1), rand_value());
                end
                else if (roll < 70)
                    send_plain(3'(KIND_UNUSED_LO + $urandom_range(2)), $urandom_range(7),
                               $urandom_range(7), $urandom);
                else if (roll < 80)
                    send_plain(3'($urandom_range(3)), $urandom_range(7), $urandom_range(7),
                               rand_value());
                else
                    fill_then_start();
            end
            fill_then_start();
            wait_drained();
        end

        $display("sent %0d words with %0d starts over 7 shapes in all three modes,",
                 words_sent, starts_sent);
        $display("checked %0d result words under three idle profiles", results_seen);
        if (fails == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/mmt_pkg.sv
hdl/mmt_ram.sv
hdl/mmt_cell.sv
hdl/matrix_multiply_tile_with_gradients.sv
test/tb_matrix_multiply_tile_with_gradients.sv
